// ===== src/awif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awif_pkg
// Shared widths, codes and reset values of the adaptive window impulse filter.
// ----------------------------------------------------------------------------
package awif_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 8;
    localparam int CFG_W    = 9;
    localparam int RADIUS_W = 2;
    localparam int REG_IDX_W = 1;

    // item commands
    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_FILTER = 1'b1
    } cmd_t;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } reg_idx_t;

    localparam logic [CFG_W-1:0] IMAGE_DIM_RESET = 9'd256;

endpackage

// ===== src/awif_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awif channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface awif_item_if;
    import awif_pkg::*;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic [PIX_W-1:0]   pixel_in;

    modport source (output valid, cmd, row_index, col_index, pixel_in, input ready);
    modport sink   (input valid, cmd, row_index, col_index, pixel_in, output ready);
endinterface

interface awif_result_if;
    import awif_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIX_W-1:0]    pixel_out;
    logic [RADIUS_W-1:0] window_radius;
    logic                out_of_range;

    modport source (output valid, pixel_out, window_radius, out_of_range, input ready);
    modport sink   (input valid, pixel_out, window_radius, out_of_range, output ready);
endinterface

interface awif_cfg_if;
    import awif_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/adaptive_window_impulse_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_window_impulse_filter
// Frame store with an adaptive window filter: min, max and floor mean over a
// clipped square window whose radius grows while the window is uniform.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  cfg       in         image_rows / image_cols register writes
//  items     in         write pixel or filter pixel at row/col
//  results   out        pixel_out, window_radius, out_of_range
//
//  a filter item scans, for each radius r tried, all (2r+1)^2 window
//  positions (out-of-bounds ones included), drains and decides, then runs
//  the divider when the mean is needed and ends in the output state;
//  out-of-range filter items go straight to the output state. reads use the
//  single frame store read port. reset clears control and the size registers
//  only; the frame store is not cleared. items are held off while a filter
//  item is in progress; a stalled result holds its register.
// ----------------------------------------------------------------------------
module adaptive_window_impulse_filter #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int MAX_RADIUS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    awif_cfg_if.sink            cfg,
    awif_item_if.sink           items,
    awif_result_if.source       results
);
    import awif_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ?
                             ((MAX_ROWS > 511) ? MAX_ROWS : 511) :
                             ((MAX_COLS > 511) ? MAX_COLS : 511);
    localparam int LIM_W   = $clog2(DIM_MAX + 1);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W   = RAD_W + 1;
    localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SUM_W   = $clog2(WIN_MAX * 255 + 1);
    localparam int N_W     = $clog2(WIN_MAX + 1);
    localparam int CNT_W   = $clog2(SUM_W + 1);

    localparam logic signed [OFS_W-1:0] OFS_ONE = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_DIV,
        ST_OUT
    } state_t;

    // registers
    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          image_rows_reg, image_rows_next;
    logic [CFG_W-1:0]          image_cols_reg, image_cols_next;
    logic [COORD_W-1:0]        row_reg, row_next;
    logic [COORD_W-1:0]        col_reg, col_next;
    logic [RAD_W-1:0]          radius_reg, radius_next;
    logic signed [OFS_W-1:0]   dr_reg, dr_next;
    logic signed [OFS_W-1:0]   dc_reg, dc_next;
    logic [PIX_W-1:0]          zmin_reg, zmin_next;
    logic [PIX_W-1:0]          zmax_reg, zmax_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [N_W-1:0]            n_reg, n_next;
    logic [PIX_W-1:0]          centre_reg, centre_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic                      rd_centre_reg, rd_centre_next;
    logic [SUM_W-1:0]          div_q_reg, div_q_next;
    logic [N_W-1:0]            div_r_reg, div_r_next;
    logic [CNT_W-1:0]          div_cnt_reg, div_cnt_next;
    logic [PIX_W-1:0]          res_pixel_reg, res_pixel_next;
    logic                      res_oor_reg, res_oor_next;
    logic                      out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]          out_pixel_reg, out_pixel_next;
    logic [RADIUS_W-1:0]       out_radius_reg, out_radius_next;
    logic                      out_oor_reg, out_oor_next;

    // frame store
    logic [PIX_W-1:0]          mem [DEPTH];
    logic [PIX_W-1:0]          mem_rdata_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;

    logic                      item_fire;
    logic                      item_inside;
    logic [LIM_W-1:0]          rows_lim;
    logic [LIM_W-1:0]          cols_lim;
    logic signed [LIM_W:0]     y_pos;
    logic signed [LIM_W:0]     x_pos;
    logic                      pos_inside;
    logic signed [OFS_W-1:0]   rad_ofs;
    logic [RAD_W-1:0]          radius_inc;
    logic [N_W:0]              div_rem_sh;
    logic                      div_ge;

    // effective image size, clipped to the store size
    assign rows_lim = (LIM_W'(image_rows_reg) > LIM_W'(MAX_ROWS)) ?
                      LIM_W'(MAX_ROWS) : LIM_W'(image_rows_reg);
    assign cols_lim = (LIM_W'(image_cols_reg) > LIM_W'(MAX_COLS)) ?
                      LIM_W'(MAX_COLS) : LIM_W'(image_cols_reg);

    assign items.ready = (state_reg == ST_IDLE);
    assign item_fire   = items.valid && items.ready;
    assign item_inside = (LIM_W'(items.row_index) < rows_lim) &&
                         (LIM_W'(items.col_index) < cols_lim);

    // configuration port is always free
    assign cfg.ready = 1'b1;

    // window position under scan
    assign y_pos = signed'({1'b0, LIM_W'(row_reg)}) + (LIM_W + 1)'(dr_reg);
    assign x_pos = signed'({1'b0, LIM_W'(col_reg)}) + (LIM_W + 1)'(dc_reg);
    assign pos_inside = !y_pos[LIM_W] && (y_pos[LIM_W-1:0] < rows_lim) &&
                        !x_pos[LIM_W] && (x_pos[LIM_W-1:0] < cols_lim);
    assign rad_ofs    = signed'(OFS_W'(radius_reg));
    assign radius_inc = radius_reg + RAD_W'(1);

    // store addressing
    assign mem_we    = item_fire && (items.cmd == CMD_WRITE) && item_inside;
    assign mem_waddr = AW'(items.row_index) * AW'(MAX_COLS) + AW'(items.col_index);
    assign mem_raddr = AW'(y_pos[LIM_W-1:0]) * AW'(MAX_COLS) + AW'(x_pos[LIM_W-1:0]);

    // restoring divider step
    assign div_rem_sh = {div_r_reg, div_q_reg[SUM_W-1]};
    assign div_ge     = div_rem_sh >= {1'b0, n_reg};

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        image_rows_next = image_rows_reg;
        image_cols_next = image_cols_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        radius_next     = radius_reg;
        dr_next         = dr_reg;
        dc_next         = dc_reg;
        zmin_next       = zmin_reg;
        zmax_next       = zmax_reg;
        sum_next        = sum_reg;
        n_next          = n_reg;
        centre_next     = centre_reg;
        rd_valid_next   = 1'b0;
        rd_centre_next  = 1'b0;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_cnt_next    = div_cnt_reg;
        res_pixel_next  = res_pixel_reg;
        res_oor_next    = res_oor_reg;
        out_valid_next  = out_valid_reg;
        out_pixel_next  = out_pixel_reg;
        out_radius_next = out_radius_reg;
        out_oor_next    = out_oor_reg;

        // register writes
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_ROWS: image_rows_next = cfg.data;
                REG_IMAGE_COLS: image_cols_next = cfg.data;
                default: ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        // fold returned window pixel into the statistics
        if (rd_valid_reg)
        begin
            if (mem_rdata_reg < zmin_reg)
            begin
                zmin_next = mem_rdata_reg;
            end
            if (mem_rdata_reg > zmax_reg)
            begin
                zmax_next = mem_rdata_reg;
            end
            sum_next = sum_reg + SUM_W'(mem_rdata_reg);
            n_next   = n_reg + N_W'(1);
            if (rd_centre_reg)
            begin
                centre_next = mem_rdata_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (items.cmd == CMD_FILTER))
                begin
                    row_next    = items.row_index;
                    col_next    = items.col_index;
                    radius_next = RAD_W'(1);
                    if (!item_inside)
                    begin
                        res_pixel_next = '0;
                        res_oor_next   = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        res_oor_next = 1'b0;
                        dr_next      = -OFS_ONE;
                        dc_next      = -OFS_ONE;
                        zmin_next    = '1;
                        zmax_next    = '0;
                        sum_next     = '0;
                        n_next       = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                rd_valid_next  = pos_inside;
                rd_centre_next = (dr_reg == '0) && (dc_reg == '0);
                if (dc_reg == rad_ofs)
                begin
                    dc_next = -rad_ofs;
                    if (dr_reg == rad_ofs)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        dr_next = dr_reg + OFS_ONE;
                    end
                end
                else
                begin
                    dc_next = dc_reg + OFS_ONE;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if ((zmin_reg < zmax_reg) && (centre_reg > zmin_reg) &&
                    (centre_reg < zmax_reg))
                begin
                    res_pixel_next = centre_reg;
                    state_next     = ST_OUT;
                end
                else if ((zmin_reg < zmax_reg) || (radius_reg == RAD_W'(MAX_RADIUS)))
                begin
                    div_q_next   = sum_reg;
                    div_r_next   = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    radius_next = radius_inc;
                    dr_next     = -signed'(OFS_W'(radius_inc));
                    dc_next     = -signed'(OFS_W'(radius_inc));
                    zmin_next   = '1;
                    zmax_next   = '0;
                    sum_next    = '0;
                    n_next      = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_DIV:
            begin
                div_q_next   = {div_q_reg[SUM_W-2:0], div_ge};
                div_r_next   = div_ge ? N_W'(div_rem_sh - {1'b0, n_reg}) :
                                        div_rem_sh[N_W-1:0];
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    res_pixel_next = div_q_next[PIX_W-1:0];
                    state_next     = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pixel_next  = res_pixel_reg;
                    out_radius_next = RADIUS_W'(radius_reg);
                    out_oor_next    = res_oor_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            image_rows_reg <= IMAGE_DIM_RESET;
            image_cols_reg <= IMAGE_DIM_RESET;
            rd_valid_reg   <= 1'b0;
            rd_centre_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            image_rows_reg <= image_rows_next;
            image_cols_reg <= image_cols_next;
            rd_valid_reg   <= rd_valid_next;
            rd_centre_reg  <= rd_centre_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        radius_reg     <= radius_next;
        dr_reg         <= dr_next;
        dc_reg         <= dc_next;
        zmin_reg       <= zmin_next;
        zmax_reg       <= zmax_next;
        sum_reg        <= sum_next;
        n_reg          <= n_next;
        centre_reg     <= centre_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_cnt_reg    <= div_cnt_next;
        res_pixel_reg  <= res_pixel_next;
        res_oor_reg    <= res_oor_next;
        out_pixel_reg  <= out_pixel_next;
        out_radius_reg <= out_radius_next;
        out_oor_reg    <= out_oor_next;
    end

    // frame store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= items.pixel_in;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign results.valid         = out_valid_reg;
    assign results.pixel_out     = out_pixel_reg;
    assign results.window_radius = out_radius_reg;
    assign results.out_of_range  = out_oor_reg;

    // checks
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (n_reg != '0))
        else $error("divider started with an empty window");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("store read returned outside a window scan");

    a_decide_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (zmin_reg <= zmax_reg))
        else $error("window minimum above maximum at decision");

    a_oor_result: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.out_of_range) |->
            ((results.pixel_out == '0) && (results.window_radius == RADIUS_W'(1))))
        else $error("out-of-range result carries pixel or radius");

endmodule

// ===== test/adaptive_window_impulse_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_window_impulse_filter_test
// Self-checking bench for the adaptive window filter. A directed walk covers
// size extremes, out-of-range positions and radius growth, with typed expected
// results; random phases then fill parts of the frame, filter inside them and
// probe outside, checked against a local frame copy and window predictor.
// ----------------------------------------------------------------------------
module adaptive_window_impulse_filter_test;
    import awif_pkg::*;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_COLS     = 256;
    localparam int MAX_RADIUS   = 3;
    localparam int ITEM_TARGET  = 1350;
    localparam int PHASE_ITEMS  = 60;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel;
        logic [RADIUS_W-1:0] radius;
        logic                oor;
    } filter_result_t;

    typedef enum logic [1:0] {
        STEP_REG,
        STEP_ITEM,
        STEP_TYPED
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        reg_idx_t           reg_idx;
        logic [CFG_W-1:0]   reg_value;
        cmd_t               cmd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
        filter_result_t     typed;
    } step_t;

    typedef enum int {
        STYLE_FLAT,
        STYLE_IMPULSE,
        STYLE_TWO_LEVEL,
        STYLE_NOISE
    } pixel_style_t;

    localparam filter_result_t NO_RESULT    = '0;
    localparam filter_result_t OUT_OF_RANGE = '{8'd0, 2'd1, 1'b1};

    // directed walk: sizes, extremes, out-of-range and radius growth
    localparam int NUM_STEPS = 31;
    localparam step_t DIRECTED_STEPS [0:NUM_STEPS-1] = '{
        '{STEP_REG,   REG_IMAGE_ROWS, 9'd2,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_REG,   REG_IMAGE_COLS, 9'd2,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd1,   8'd255, NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd1,   8'd0,   8'd255, NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd1,   8'd1,   8'd255, NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd0,   8'd0,
          '{8'd191, 2'd1, 1'b0}},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd1,   8'd0,
          '{8'd191, 2'd1, 1'b0}},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd1,   8'd1,   8'd100, NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd1,   8'd1,   8'd0,
          '{8'd100, 2'd1, 1'b0}},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd2,   8'd0,   8'd0,   OUT_OF_RANGE},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd2,   8'd0,   OUT_OF_RANGE},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd255, 8'd255, 8'd255, OUT_OF_RANGE},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd5,   8'd5,   8'd77,  NO_RESULT},
        '{STEP_REG,   REG_IMAGE_ROWS, 9'd1,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_REG,   REG_IMAGE_COLS, 9'd3,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd1,   8'd0,   NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd2,   8'd90,  NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd0,   8'd0,
          '{8'd30, 2'd2, 1'b0}},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd2,   8'd0,   NO_RESULT},
        '{STEP_REG,   REG_IMAGE_COLS, 9'd1,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd0,   8'd0,
          '{8'd0, 2'd3, 1'b0}},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd0,   8'd255, NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd0,   8'd0,
          '{8'd255, 2'd3, 1'b0}},
        '{STEP_REG,   REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd0,   8'd0,   8'd0,   OUT_OF_RANGE},
        '{STEP_REG,   REG_IMAGE_ROWS, 9'd511, CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_REG,   REG_IMAGE_COLS, 9'd0,   CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_TYPED, REG_IMAGE_ROWS, 9'd0,   CMD_FILTER, 8'd255, 8'd0,   8'd0,   OUT_OF_RANGE},
        '{STEP_REG,   REG_IMAGE_COLS, 9'd511, CMD_WRITE,  8'd0,   8'd0,   8'd0,   NO_RESULT},
        '{STEP_ITEM,  REG_IMAGE_ROWS, 9'd0,   CMD_WRITE,  8'd255, 8'd255, 8'd200, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    awif_cfg_if    cfg_ch ();
    awif_item_if   item_ch ();
    awif_result_if result_ch ();

    adaptive_window_impulse_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (result_ch)
    );

    // local copy of the frame store and of the size registers
    logic [PIX_W-1:0] frame_copy [0:MAX_ROWS*MAX_COLS-1];
    bit               written_map [0:MAX_ROWS*MAX_COLS-1];
    logic [CFG_W-1:0] rows_setting = IMAGE_DIM_RESET;
    logic [CFG_W-1:0] cols_setting = IMAGE_DIM_RESET;

    filter_result_t   expected_results [$];
    int unsigned      mismatch_count = 0;
    int unsigned      item_count = 0;
    int unsigned      burst_left = 0;
    int unsigned      cycle_count = 0;
    pixel_style_t     pixel_style = STYLE_NOISE;
    logic [PIX_W-1:0] pixel_base = 8'd0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned effective(input logic [CFG_W-1:0] v, input int unsigned cap);
        return (v > cap) ? cap : int'(v);
    endfunction

    // expected result of a filter item at the current size and frame contents
    function automatic filter_result_t predict_filter(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
        filter_result_t res;
        int unsigned    rows, cols, lo, hi, sum, n, s;
        int             y, x;
        logic [PIX_W-1:0] centre;
        rows = effective(rows_setting, MAX_ROWS);
        cols = effective(cols_setting, MAX_COLS);
        res = OUT_OF_RANGE;
        if (row >= rows || col >= cols)
            return res;
        centre = frame_copy[{row, col}];
        res.oor = 1'b0;
        for (int r = 1; r <= MAX_RADIUS; r++)
        begin
            lo = 255;
            hi = 0;
            sum = 0;
            n = 0;
            for (int dy = -r; dy <= r; dy++)
            begin
                y = int'(row) + dy;
                if (y < 0 || y >= int'(rows))
                    continue;
                for (int dx = -r; dx <= r; dx++)
                begin
                    x = int'(col) + dx;
                    if (x < 0 || x >= int'(cols))
                        continue;
                    s = frame_copy[y * MAX_COLS + x];
                    if (s > hi)
                        hi = s;
                    if (s < lo)
                        lo = s;
                    sum += s;
                    n++;
                end
            end
            res.radius = 2'(r);
            res.pixel  = 8'(sum / n);
            // exact mean strictly inside the range: decide at this radius
            if (sum > lo * n && sum < hi * n)
            begin
                if (centre > lo && centre < hi)
                    res.pixel = centre;
                break;
            end
        end
        return res;
    endfunction

    // true when every in-bounds pixel of the widest window has been written
    function automatic bit window_written(input logic [COORD_W-1:0] row,
                                          input logic [COORD_W-1:0] col);
        int unsigned rows, cols;
        int          y, x;
        rows = effective(rows_setting, MAX_ROWS);
        cols = effective(cols_setting, MAX_COLS);
        for (int dy = -MAX_RADIUS; dy <= MAX_RADIUS; dy++)
        begin
            y = int'(row) + dy;
            if (y < 0 || y >= int'(rows))
                continue;
            for (int dx = -MAX_RADIUS; dx <= MAX_RADIUS; dx++)
            begin
                x = int'(col) + dx;
                if (x >= 0 && x < int'(cols) && !written_map[y * MAX_COLS + x])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // grey values shaped so that flat windows and impulses both occur
    function automatic logic [PIX_W-1:0] next_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (pixel_style)
            STYLE_FLAT:      return (roll < 96) ? pixel_base : 8'($urandom);
            STYLE_IMPULSE:
            begin
                if (roll < 80)
                    return pixel_base;
                if (roll < 89)
                    return 8'd0;
                if (roll < 98)
                    return 8'd255;
                return 8'($urandom);
            end
            STYLE_TWO_LEVEL: return (roll < 50) ? pixel_base : pixel_base + 8'd1;
            default:         return 8'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 9'($urandom_range(1, 16));
        if (roll < 85)
            return 9'($urandom_range(17, 256));
        if (roll < 95)
            return 9'($urandom_range(257, 511));
        return 9'd0;
    endfunction

    // one item transfer, with burst gaps; updates the frame copy on acceptance
    task automatic send_item(input cmd_t cmd, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [PIX_W-1:0] pix,
                             input bit typed, input filter_result_t typed_res);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 6);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= cmd;
        item_ch.row_index <= row;
        item_ch.col_index <= col;
        item_ch.pixel_in  <= pix;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (cmd == CMD_FILTER)
        begin
            expected_results.push_back(typed ? typed_res : predict_filter(row, col));
            item_count++;
        end
        else if (row < effective(rows_setting, MAX_ROWS) &&
                 col < effective(cols_setting, MAX_COLS))
        begin
            frame_copy[{row, col}]  = pix;
            written_map[{row, col}] = 1'b1;
            item_count++;
        end
    endtask

    // let all results drain, then let writes settle
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_IMAGE_ROWS)
            rows_setting = value;
        else
            cols_setting = value;
    endtask

    // one size setting: fill a block, then filter, rewrite and probe outside
    task automatic run_phase(input logic [CFG_W-1:0] rows_val,
                             input logic [CFG_W-1:0] cols_val, input bit corner);
        int unsigned er, ec, h, w, r0, c0, sel, tries;
        logic [COORD_W-1:0] r, c;
        wait_idle();
        write_reg(REG_IMAGE_ROWS, rows_val);
        write_reg(REG_IMAGE_COLS, cols_val);
        er = effective(rows_val, MAX_ROWS);
        ec = effective(cols_val, MAX_COLS);
        pixel_style = pixel_style_t'($urandom_range(0, 3));
        pixel_base  = 8'($urandom);
        h  = (er <= 10) ? er : $urandom_range(7, 10);
        w  = (ec <= 10) ? ec : $urandom_range(7, 10);
        r0 = (er <= 10) ? 0 : (corner ? er - h : $urandom_range(0, er - h));
        c0 = (ec <= 10) ? 0 : (corner ? ec - w : $urandom_range(0, ec - w));

        // fill the block before any filter reads it
        if (h > 0 && w > 0)
            for (int i = 0; i < h; i++)
                for (int j = 0; j < w; j++)
                    send_item(CMD_WRITE, 8'(r0 + i), 8'(c0 + j), next_pixel(), 1'b0, NO_RESULT);

        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            sel = $urandom_range(0, 99);
            if ((sel >= 85 || h == 0 || w == 0) && (er < MAX_ROWS || ec < MAX_COLS))
            begin
                // position outside the configured size
                if (er < MAX_ROWS && (ec == MAX_COLS || $urandom_range(0, 1) == 1))
                begin
                    r = 8'($urandom_range(er, 255));
                    c = 8'($urandom);
                end
                else
                begin
                    r = 8'($urandom);
                    c = 8'($urandom_range(ec, 255));
                end
                send_item((sel % 2 == 0) ? CMD_FILTER : CMD_WRITE, r, c, 8'($urandom),
                          1'b0, NO_RESULT);
            end
            else if (h > 0 && w > 0)
            begin
                r = 8'(r0 + $urandom_range(0, h - 1));
                c = 8'(c0 + $urandom_range(0, w - 1));
                if (sel < 60)
                    for (tries = 0; tries < 16 && !window_written(r, c); tries++)
                    begin
                        r = 8'(r0 + $urandom_range(0, h - 1));
                        c = 8'(c0 + $urandom_range(0, w - 1));
                    end
                if (sel < 60 && window_written(r, c))
                    send_item(CMD_FILTER, r, c, 8'($urandom), 1'b0, NO_RESULT);
                else
                    send_item(CMD_WRITE, r, c, next_pixel(), 1'b0, NO_RESULT);
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_IMAGE_ROWS;
        cfg_ch.data       = '0;
        item_ch.valid     = 1'b0;
        item_ch.cmd       = CMD_WRITE;
        item_ch.row_index = '0;
        item_ch.col_index = '0;
        item_ch.pixel_in  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if (DIRECTED_STEPS[i].kind == STEP_REG)
            begin
                wait_idle();
                write_reg(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_value);
            end
            else
                send_item(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].row, DIRECTED_STEPS[i].col,
                          DIRECTED_STEPS[i].pix, DIRECTED_STEPS[i].kind == STEP_TYPED,
                          DIRECTED_STEPS[i].typed);
        end

        // size extremes first, then random sizes
        run_phase(9'd256, 9'd256, 1'b0);
        run_phase(9'd511, 9'd511, 1'b1);
        run_phase(9'd1,   9'd1,   1'b0);
        run_phase(9'd1,   9'd256, 1'b0);
        run_phase(9'd256, 9'd1,   1'b1);
        run_phase(9'd0,   9'd200, 1'b0);
        run_phase(9'd200, 9'd0,   1'b0);
        run_phase(9'd8,   9'd8,   1'b0);
        while (item_count < ITEM_TARGET)
            run_phase(random_dim(), random_dim(), $urandom_range(0, 1) == 1);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("adaptive_window_impulse_filter_test OK");
        else
            $display("adaptive_window_impulse_filter_test NOT OK");
        $finish;
    end

    // result back-pressure, changing pattern every so often
    initial
    begin : receiver_stalls
        int unsigned mode, mode_left;
        result_ch.ready = 1'b0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end
            else
                mode_left--;
            case (mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ($urandom_range(0, 31) == 0);
            endcase
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatch_count++;
            end
            else
            begin
                if (result_ch.pixel_out !== expected_results[0].pixel)
                begin
                    $error("pixel_out: expected %0d, got %0d",
                           expected_results[0].pixel, result_ch.pixel_out);
                    mismatch_count++;
                end
                if (result_ch.window_radius !== expected_results[0].radius)
                begin
                    $error("window_radius: expected %0d, got %0d",
                           expected_results[0].radius, result_ch.window_radius);
                    mismatch_count++;
                end
                if (result_ch.out_of_range !== expected_results[0].oor)
                begin
                    $error("out_of_range: expected %0d, got %0d",
                           expected_results[0].oor, result_ch.out_of_range);
                    mismatch_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("adaptive_window_impulse_filter_test NOT OK");
            $finish;
        end
    end

endmodule
